// ----- hw/rtl/avclap_pkg.sv -----
// ----------------------------------------------------------------------------
// avclap_pkg
// Shared constants for the clapper overlay: register map, reset values,
// field widths, frame rates, flash color and reciprocal multipliers.
// ----------------------------------------------------------------------------
package avclap_pkg;

	localparam int COORD_W  = 12;
	localparam int PHASE_W  = 5;
	localparam int PIX_W    = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_DIM_W  = 13;
	localparam int COLOUR_W   = 24;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IS_PAL       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BAR_COLOR    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_COLOR    = 3'd4;

	localparam logic [CFG_DIM_W-1:0] RST_FRAME_WIDTH  = 13'd720;
	localparam logic [CFG_DIM_W-1:0] RST_FRAME_HEIGHT = 13'd576;
	localparam logic                 RST_IS_PAL       = 1'b1;
	localparam logic [COLOUR_W-1:0]  RST_BAR_COLOR    = 24'h913622;
	localparam logic [COLOUR_W-1:0]  RST_OFF_COLOR    = 24'h108080;

	localparam int FPS_PAL  = 25;
	localparam int FPS_NTSC = 30;
	localparam logic [PHASE_W-1:0] LAST_PHASE_PAL  = 5'd24;
	localparam logic [PHASE_W-1:0] LAST_PHASE_NTSC = 5'd29;
	localparam logic [PHASE_W-1:0] FLASH_PHASE_PAL  = 5'd12;
	localparam logic [PHASE_W-1:0] FLASH_PHASE_NTSC = 5'd14;

	localparam int FLASH_MARGIN = 12;
	localparam int BAR_MIN_H    = 4;

	// Red flash packed like the color registers: Y, U, V.
	localparam logic [COLOUR_W-1:0] FLASH_COLOUR = 24'h4b5fe6;

	// Geometry settles through this many register stages after a change.
	localparam int GEOM_STAGES = 4;
	localparam int SETTLE_W    = 3;

	// Floor division by a constant as (x * K) >> RECIP_SHIFT, exact over the
	// operand ranges used here.
	localparam int RECIP_SHIFT = 20;
	localparam int RECIP_W     = 17;
	localparam int RECIP_10 = 104858;
	localparam int RECIP_15 = 69906;
	localparam int RECIP_25 = 41944;
	localparam int RECIP_30 = 34953;

endpackage

// ----- hw/rtl/av_sync_clapper_overlay_unit.sv -----
// ----------------------------------------------------------------------------
// av_sync_clapper_overlay_unit
// Paints the frame-phase progress bar and the sync flash into UYVY pixel
// pairs of a static background frame.
// ----------------------------------------------------------------------------
// The unit takes one pixel pair per clock while in_ready is high and returns it
// through a four-stage pipeline whose last stage is the output register; a
// stalled output holds the pipeline without losing or repeating an item.
// All geometry is derived from the size and rate registers in a separate
// four-stage pipeline, so after reset and after every configuration write
// in_ready stays low while that geometry settles.
module av_sync_clapper_overlay_unit #(
	parameter int MAX_DIM = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [avclap_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [avclap_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [avclap_pkg::COORD_W-1:0]      col,
	input  logic [avclap_pkg::COORD_W-1:0]      row,
	input  logic [avclap_pkg::PHASE_W-1:0]      frame_phase,
	input  logic [avclap_pkg::PIX_W-1:0]        in_u,
	input  logic [avclap_pkg::PIX_W-1:0]        in_y0,
	input  logic [avclap_pkg::PIX_W-1:0]        in_v,
	input  logic [avclap_pkg::PIX_W-1:0]        in_y1,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [avclap_pkg::PIX_W-1:0]        out_u,
	output logic [avclap_pkg::PIX_W-1:0]        out_y0,
	output logic [avclap_pkg::PIX_W-1:0]        out_v,
	output logic [avclap_pkg::PIX_W-1:0]        out_y1
);
	import avclap_pkg::*;

	localparam int DW = $clog2(MAX_DIM + 1);
	localparam int AW = (DW > COORD_W) ? DW : COORD_W;
	localparam int SW = AW + 3;

	logic [CFG_DIM_W-1:0] frame_width_q, frame_height_q;
	logic                 is_pal_q;
	logic [COLOUR_W-1:0]  bar_color_q, off_color_q;
	logic [SETTLE_W-1:0]  settle_q;
	logic                 cfg_take;

	logic [DW-1:0]        bar_h, tick, width;
	logic signed [SW-1:0] bar_top, span_start;
	logic [SW-1:0]        span_lim;
	logic                 pal;

	assign cfg_ready = 1'b1;
	assign cfg_take  = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= RST_FRAME_WIDTH;
			frame_height_q <= RST_FRAME_HEIGHT;
			is_pal_q       <= RST_IS_PAL;
			bar_color_q    <= RST_BAR_COLOR;
			off_color_q    <= RST_OFF_COLOR;
			settle_q       <= SETTLE_W'(GEOM_STAGES);
		end else begin
			if (cfg_take) begin
				settle_q <= SETTLE_W'(GEOM_STAGES);
				unique case (cfg_index)
					REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[CFG_DIM_W-1:0];
					REG_FRAME_HEIGHT: frame_height_q <= cfg_data[CFG_DIM_W-1:0];
					REG_IS_PAL:       is_pal_q       <= cfg_data[0];
					REG_BAR_COLOR:    bar_color_q    <= cfg_data[COLOUR_W-1:0];
					REG_OFF_COLOR:    off_color_q    <= cfg_data[COLOUR_W-1:0];
					default: begin
					end
				endcase
			end else if (settle_q != '0) begin
				settle_q <= settle_q - SETTLE_W'(1);
			end
		end
	end

	avclap_geom #(
		.MAX_DIM (MAX_DIM)
	) u_geom (
		.clk          (clk),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.is_pal       (is_pal_q),
		.bar_h        (bar_h),
		.tick         (tick),
		.bar_top      (bar_top),
		.span_start   (span_start),
		.span_lim     (span_lim),
		.width        (width),
		.pal          (pal)
	);

	avclap_pipe #(
		.MAX_DIM (MAX_DIM)
	) u_pipe (
		.clk          (clk),
		.arst_n       (arst_n),
		.hold         (settle_q != '0),
		.bar_h        (bar_h),
		.tick         (tick),
		.bar_top      (bar_top),
		.span_start   (span_start),
		.span_lim     (span_lim),
		.width        (width),
		.pal          (pal),
		.bar_color    (bar_color_q),
		.off_color    (off_color_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.col          (col),
		.row          (row),
		.frame_phase  (frame_phase),
		.in_u         (in_u),
		.in_y0        (in_y0),
		.in_v         (in_v),
		.in_y1        (in_y1),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_u        (out_u),
		.out_y0       (out_y0),
		.out_v        (out_v),
		.out_y1       (out_y1)
	);

endmodule

// ----- hw/rtl/avclap_geom.sv -----
// ----------------------------------------------------------------------------
// avclap_geom
// Four-stage pipeline that derives the bar and flash geometry from the frame
// size and rate registers: bar height, tick spacing, bar top and bar span.
// ----------------------------------------------------------------------------
module avclap_geom #(
	parameter int MAX_DIM = 4096,
	localparam int DW = $clog2(MAX_DIM + 1),
	localparam int AW = (DW > avclap_pkg::COORD_W) ? DW : avclap_pkg::COORD_W,
	localparam int SW = AW + 3
) (
	input  logic                                 clk,
	input  logic [avclap_pkg::CFG_DIM_W-1:0]     frame_width,
	input  logic [avclap_pkg::CFG_DIM_W-1:0]     frame_height,
	input  logic                                 is_pal,
	output logic [DW-1:0]                        bar_h,
	output logic [DW-1:0]                        tick,
	output logic signed [SW-1:0]                 bar_top,
	output logic signed [SW-1:0]                 span_start,
	output logic [SW-1:0]                        span_lim,
	output logic [DW-1:0]                        width,
	output logic                                 pal
);
	import avclap_pkg::*;

	localparam int CW = (DW > CFG_DIM_W) ? DW : CFG_DIM_W;
	localparam int PW = RECIP_SHIFT + DW + 2;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_DIM);
	localparam logic signed [SW-1:0] ONE_S = SW'(1);

	logic [CW-1:0] fw_x, fh_x;
	logic [DW-1:0] w_sat, h_sat;
	logic [PW-1:0] p15, p10, pfps;
	logic [DW-1:0] q15, h10;

	logic [DW-1:0] w_s1, h_s1, q15_s1, h10_s1;
	logic          pal_s1;

	logic [DW-1:0] bh_c, num_c, td_c;
	logic [DW-1:0] w_s2, h_s2, bh_s2, td_s2;
	logic          pal_s2;

	logic [DW+4:0]        ftd;
	logic [DW-1:0]        xm_c;
	logic signed [SW-1:0] y0r, y0_c;
	logic [DW-1:0]        w_s3, bh_s3, td_s3, xm_s3;
	logic signed [SW-1:0] y0_s3;
	logic                 pal_s3;

	logic signed [SW-1:0] half, s_c, e_c, span;
	logic [SW-1:0]        lim_c;

	always_comb begin
		fw_x  = CW'(frame_width);
		fh_x  = CW'(frame_height);
		w_sat = (fw_x > MAX_C) ? DW'(MAX_DIM) : DW'(fw_x);
		h_sat = (fh_x > MAX_C) ? DW'(MAX_DIM) : DW'(fh_x);
		p15   = PW'({w_sat, 1'b0}) * PW'(RECIP_15);
		p10   = PW'(h_sat) * PW'(RECIP_10);
		q15   = p15[RECIP_SHIFT +: DW];
		h10   = p10[RECIP_SHIFT +: DW];
	end

	always_ff @(posedge clk) begin
		w_s1   <= w_sat;
		h_s1   <= h_sat;
		q15_s1 <= q15;
		h10_s1 <= h10;
		pal_s1 <= is_pal;
	end

	always_comb begin
		if (h10_s1 < DW'(BAR_MIN_H)) begin
			bh_c = DW'(BAR_MIN_H);
		end else begin
			bh_c = h10_s1 + DW'(h10_s1[0]);
		end
		num_c = w_s1 - q15_s1;
		pfps  = PW'(num_c) * (pal_s1 ? PW'(RECIP_25) : PW'(RECIP_30));
		td_c  = pfps[RECIP_SHIFT +: DW];
	end

	always_ff @(posedge clk) begin
		w_s2   <= w_s1;
		h_s2   <= h_s1;
		bh_s2  <= bh_c;
		td_s2  <= td_c;
		pal_s2 <= pal_s1;
	end

	always_comb begin
		ftd  = (DW+5)'(td_s2) * (pal_s2 ? (DW+5)'(FPS_PAL) : (DW+5)'(FPS_NTSC));
		xm_c = (w_s2 - DW'(ftd)) >> 1;
		y0r  = $signed(SW'(h_s2 >> 1)) - $signed(SW'(bh_s2 >> 1));
		if (!y0r[0]) begin
			y0_c = y0r;
		end else if (y0r[SW-1]) begin
			y0_c = y0r - ONE_S;
		end else begin
			y0_c = y0r + ONE_S;
		end
	end

	always_ff @(posedge clk) begin
		w_s3   <= w_s2;
		bh_s3  <= bh_s2;
		td_s3  <= td_s2;
		xm_s3  <= xm_c;
		y0_s3  <= y0_c;
		pal_s3 <= pal_s2;
	end

	always_comb begin
		half = $signed(SW'(td_s3 >> 1));
		s_c  = $signed(SW'(xm_s3)) - half;
		e_c  = $signed(SW'(w_s3)) - $signed(SW'(xm_s3)) + half;
		span = e_c - s_c + ONE_S;
		if (e_c > s_c) begin
			lim_c = {span[SW-2:1], 2'b00};
		end else begin
			lim_c = '0;
		end
	end

	always_ff @(posedge clk) begin
		bar_h      <= bh_s3;
		tick       <= td_s3;
		bar_top    <= y0_s3;
		span_start <= s_c;
		span_lim   <= lim_c;
		width      <= w_s3;
		pal        <= pal_s3;
	end

endmodule

// ----- hw/rtl/avclap_pipe.sv -----
// ----------------------------------------------------------------------------
// avclap_pipe
// Four-stage pixel pipeline with one lane per byte of the UYVY pair: bar
// hit test, tick threshold, color selection and flash override.
// ----------------------------------------------------------------------------
module avclap_pipe #(
	parameter int MAX_DIM = 4096,
	localparam int DW = $clog2(MAX_DIM + 1),
	localparam int AW = (DW > avclap_pkg::COORD_W) ? DW : avclap_pkg::COORD_W,
	localparam int SW = AW + 3
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                hold,
	input  logic [DW-1:0]                       bar_h,
	input  logic [DW-1:0]                       tick,
	input  logic signed [SW-1:0]                bar_top,
	input  logic signed [SW-1:0]                span_start,
	input  logic [SW-1:0]                       span_lim,
	input  logic [DW-1:0]                       width,
	input  logic                                pal,
	input  logic [avclap_pkg::COLOUR_W-1:0]     bar_color,
	input  logic [avclap_pkg::COLOUR_W-1:0]     off_color,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [avclap_pkg::COORD_W-1:0]      col,
	input  logic [avclap_pkg::COORD_W-1:0]      row,
	input  logic [avclap_pkg::PHASE_W-1:0]      frame_phase,
	input  logic [avclap_pkg::PIX_W-1:0]        in_u,
	input  logic [avclap_pkg::PIX_W-1:0]        in_y0,
	input  logic [avclap_pkg::PIX_W-1:0]        in_v,
	input  logic [avclap_pkg::PIX_W-1:0]        in_y1,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [avclap_pkg::PIX_W-1:0]        out_u,
	output logic [avclap_pkg::PIX_W-1:0]        out_y0,
	output logic [avclap_pkg::PIX_W-1:0]        out_v,
	output logic [avclap_pkg::PIX_W-1:0]        out_y1
);
	import avclap_pkg::*;

	localparam int TW = DW + PHASE_W;
	localparam int KW = SW + PHASE_W;
	localparam int LANES = 4;
	localparam logic [1:0] POS_U = 2'd0;
	localparam logic [1:0] POS_V = 2'd2;

	function automatic logic [PIX_W-1:0] comp_of(input logic [COLOUR_W-1:0] c,
			input logic [1:0] pos);
		logic [PIX_W-1:0] r;
		unique case (pos)
			POS_U:   r = c[15:8];
			POS_V:   r = c[7:0];
			default: r = c[23:16];
		endcase
		return r;
	endfunction

	logic en1, en2, en3, en4, take;

	logic                   v_s1, v_s2, v_s3, v_s4;
	logic [COORD_W-1:0]     col_s1, row_s1;
	logic [PHASE_W-1:0]     ph_s1;
	logic [PIX_W-1:0]       px_s1 [LANES];

	logic [PHASE_W-1:0]     last_ph, ph_c, ph1_c;
	logic signed [SW-1:0]   r_c, b_c [LANES], d_c [LANES];
	logic                   in_bar_c, fz_c, fon_c;
	logic [LANES-1:0]       hit_c;
	logic [SW-1:0]          k_c [LANES];

	logic [LANES-1:0]       hit_s2;
	logic [1:0]             pos_s2 [LANES];
	logic [SW-1:0]          k_s2 [LANES];
	logic                   even_s2, fz_s2, fon_s2;
	logic [PHASE_W-1:0]     ph1_s2;
	logic [PIX_W-1:0]       px_s2 [LANES];

	logic [SW-1:0]          half_c;
	logic [TW-1:0]          thr_c;
	logic [LANES-1:0]       hit_s3, lt_s3;
	logic [1:0]             pos_s3 [LANES];
	logic [SW-1:0]          k_s3 [LANES];
	logic signed [SW-1:0]   q_s3 [LANES];
	logic [TW-1:0]          thr_s3;
	logic                   even_s3, fz_s3, fon_s3;
	logic [PIX_W-1:0]       px_s3 [LANES];

	logic [LANES-1:0]       green_c;
	logic [PIX_W-1:0]       o_c [LANES];
	logic [PIX_W-1:0]       o_s4 [LANES];

	assign en4      = !v_s4 || out_ready;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1 && !hold;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= take;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			col_s1   <= {col[COORD_W-1:1], 1'b0};
			row_s1   <= row;
			ph_s1    <= frame_phase;
			px_s1[0] <= in_u;
			px_s1[1] <= in_y0;
			px_s1[2] <= in_v;
			px_s1[3] <= in_y1;
		end
	end

	// Stage 2: phase clamp, bar row test, flash region and byte hit tests.
	always_comb begin
		last_ph  = pal ? LAST_PHASE_PAL : LAST_PHASE_NTSC;
		ph_c     = (ph_s1 > last_ph) ? last_ph : ph_s1;
		ph1_c    = ph_c + PHASE_W'(1);
		r_c      = $signed(SW'(row_s1)) - bar_top;
		in_bar_c = (tick != '0) && !r_c[SW-1] && (r_c < $signed(SW'(bar_h)));
		fz_c     = (SW'(row_s1) < SW'(bar_h)) && (SW'(col_s1) >= SW'(FLASH_MARGIN))
			&& (SW'(col_s1) + SW'(FLASH_MARGIN) < SW'(width));
		fon_c    = ph_c == (pal ? FLASH_PHASE_PAL : FLASH_PHASE_NTSC);
		for (int j = 0; j < LANES; j++) begin
			b_c[j]   = $signed(SW'({col_s1, 1'b0})) + $signed(SW'(j));
			d_c[j]   = b_c[j] - (span_start <<< 1);
			hit_c[j] = in_bar_c && (b_c[j] < $signed(SW'({width, 1'b0})))
				&& !d_c[j][SW-1] && (d_c[j] < $signed(span_lim));
			k_c[j]   = {2'b00, d_c[j][SW-2:2], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			hit_s2  <= hit_c;
			even_s2 <= !r_c[0];
			fz_s2   <= fz_c;
			fon_s2  <= fon_c;
			ph1_s2  <= ph1_c;
			for (int j = 0; j < LANES; j++) begin
				pos_s2[j] <= d_c[j][1:0];
				k_s2[j]   <= k_c[j];
				px_s2[j]  <= px_s1[j];
			end
		end
	end

	// Stage 3: phase threshold in pixels and the offsets against half a tick.
	always_comb begin
		half_c = SW'(tick >> 1);
		thr_c  = TW'(ph1_s2) * TW'(tick);
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			hit_s3  <= hit_s2;
			thr_s3  <= thr_c;
			even_s3 <= even_s2;
			fz_s3   <= fz_s2;
			fon_s3  <= fon_s2;
			for (int j = 0; j < LANES; j++) begin
				lt_s3[j]  <= k_s2[j] < half_c;
				q_s3[j]   <= $signed(k_s2[j]) - $signed(half_c);
				k_s3[j]   <= k_s2[j];
				pos_s3[j] <= pos_s2[j];
				px_s3[j]  <= px_s2[j];
			end
		end
	end

	// Stage 4: green or black per byte, then the flash over everything.
	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			if (even_s3) begin
				green_c[j] = lt_s3[j] || (KW'(k_s3[j]) < KW'(thr_s3));
			end else begin
				green_c[j] = q_s3[j][SW-1] || (KW'(q_s3[j]) < KW'(thr_s3));
			end
			if (fz_s3) begin
				o_c[j] = comp_of(fon_s3 ? FLASH_COLOUR : off_color, 2'(j));
			end else if (hit_s3[j]) begin
				o_c[j] = comp_of(green_c[j] ? bar_color : off_color, pos_s3[j]);
			end else begin
				o_c[j] = px_s3[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			for (int j = 0; j < LANES; j++) begin
				o_s4[j] <= o_c[j];
			end
		end
	end

	assign out_valid = v_s4;
	assign out_u     = o_s4[0];
	assign out_y0    = o_s4[1];
	assign out_v     = o_s4[2];
	assign out_y1    = o_s4[3];

endmodule

// ----- hw/rtl/avclap_checker.sv -----
// ----------------------------------------------------------------------------
// avclap_checker
// Port-level checks for the clapper overlay: output stall behavior, reset,
// input hold-off after configuration and pipeline latency.
// ----------------------------------------------------------------------------
module avclap_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                cfg_valid,
	input logic                                cfg_ready,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [avclap_pkg::PIX_W-1:0]        out_u,
	input logic [avclap_pkg::PIX_W-1:0]        out_y0,
	input logic [avclap_pkg::PIX_W-1:0]        out_v,
	input logic [avclap_pkg::PIX_W-1:0]        out_y1
);

	// A stalled result item keeps its bytes.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_u) && $stable(out_y0)
			&& $stable(out_v) && $stable(out_y1))
		else $error("stalled output item changed");

	// No result item is presented straight out of reset.
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("output valid right after reset");

	// The geometry must settle before a new item is taken.
	a_cfg_holdoff: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !in_ready)
		else $error("input taken while geometry settles");

	// An output register that fills from empty holds an item taken at the input and passed through each stage in turn.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 4))
		else $error("output item without matching input item");

endmodule

bind av_sync_clapper_overlay_unit avclap_checker u_avclap_checker (.*);

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for av_sync_clapper_overlay_unit. A scoreboard class
// paints each accepted pixel pair the way the overlay should and queues it;
// every returned pair is compared byte by byte against the oldest one. The
// run goes through several frame sizes, both frame rates and several color
// settings, with random sender gaps, receiver stalls and one long hold-off.
// ----------------------------------------------------------------------------
module tb;
	import avclap_pkg::*;

	localparam int CLK_PERIOD    = 20;
	localparam int RESET_CYCLES  = 8;
	localparam int DIM_LIMIT     = 4096;
	localparam int COORD_MAX     = (1 << COORD_W) - 1;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 150;
	localparam int LIMIT_CYCLES  = 200000;
	localparam int REPORT_LIMIT  = 10;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_OFF_COLOR + 3'd1;

	typedef struct packed {
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [PHASE_W-1:0] phase;
		logic [PIX_W-1:0]   u;
		logic [PIX_W-1:0]   y0;
		logic [PIX_W-1:0]   v;
		logic [PIX_W-1:0]   y1;
	} pair_in_t;

	typedef struct packed {
		logic [PIX_W-1:0] u;
		logic [PIX_W-1:0] y0;
		logic [PIX_W-1:0] v;
		logic [PIX_W-1:0] y1;
	} pair_out_t;

	typedef struct {
		pair_in_t  src;
		pair_out_t want;
	} pending_pair_t;

	class pair_scoreboard;
		logic [CFG_DIM_W-1:0] width;
		logic [CFG_DIM_W-1:0] height;
		logic                 pal;
		logic [COLOUR_W-1:0]  green;
		logic [COLOUR_W-1:0]  black;
		pending_pair_t        awaited[$];
		int                   errors;
		int                   noted;
		int                   checked;

		function new();
			width  = RST_FRAME_WIDTH;
			height = RST_FRAME_HEIGHT;
			pal    = RST_IS_PAL;
			green  = RST_BAR_COLOR;
			black  = RST_OFF_COLOR;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_FRAME_WIDTH: width = data[CFG_DIM_W-1:0];
				REG_FRAME_HEIGHT: height = data[CFG_DIM_W-1:0];
				REG_IS_PAL: pal = data[0];
				REG_BAR_COLOR: green = data[COLOUR_W-1:0];
				REG_OFF_COLOR: black = data[COLOUR_W-1:0];
				default: ;
			endcase
		endfunction

		function int flash_phase();
			return pal ? int'(FLASH_PHASE_PAL) : int'(FLASH_PHASE_NTSC);
		endfunction

		function void geometry(output int w, output int fps, output int bh, output int td,
				output int xm, output int y0, output int s, output int e);
			int h;
			w = (width > DIM_LIMIT) ? DIM_LIMIT : int'(width);
			h = (height > DIM_LIMIT) ? DIM_LIMIT : int'(height);
			fps = pal ? FPS_PAL : FPS_NTSC;
			bh = h / 10;
			if (bh < BAR_MIN_H) bh = BAR_MIN_H;
			bh += bh % 2;
			td = (w - (2 * w) / 15) / fps;
			xm = (w - fps * td) / 2;
			y0 = h / 2 - bh / 2;
			y0 += y0 % 2;
			s = xm - td / 2;
			e = w - xm + td / 2;
		endfunction

		function logic [PIX_W-1:0] colour_byte(logic [COLOUR_W-1:0] c, int pos);
			if (pos == 0) return c[15:8];
			if (pos == 2) return c[7:0];
			return c[23:16];
		endfunction

		function pair_out_t paint_pair(pair_in_t p);
			int w, fps, bh, td, xm, y0, s, e;
			int c, r, ph, off, n, b, d, i;
			logic [PIX_W-1:0] px[4];
			logic lit;
			pair_out_t q;
			geometry(w, fps, bh, td, xm, y0, s, e);
			px[0] = p.u;
			px[1] = p.y0;
			px[2] = p.v;
			px[3] = p.y1;
			c = int'(p.col) & ~1;
			r = int'(p.row);
			ph = int'(p.phase);
			if (ph >= fps) ph = fps - 1;
			off = r - y0;
			if (td > 0 && off >= 0 && off < bh) begin
				n = (e > s) ? (e - s + 1) / 2 : 0;
				for (int k = 0; k < 4; k++) begin
					b = 2 * c + k;
					d = b - 2 * s;
					if (b < 2 * w && d >= 0 && d < 4 * n) begin
						i = s + 2 * (d / 4);
						if (off % 2 == 0)
							lit = ((i - s) < td / 2) || ((i - s) / td <= ph);
						else
							lit = (i - xm) / td <= ph;
						px[k] = colour_byte(lit ? green : black, d % 4);
					end
				end
			end
			if (r < bh && c >= FLASH_MARGIN && c < w - FLASH_MARGIN) begin
				for (int k = 0; k < 4; k++)
					px[k] = colour_byte((ph == flash_phase()) ? FLASH_COLOUR : black, k);
			end
			q = '{px[0], px[1], px[2], px[3]};
			return q;
		endfunction

		function void complain(string msg);
			errors++;
			if (errors <= REPORT_LIMIT) $display("%s", msg);
		endfunction

		function void note_pair(pair_in_t p);
			pending_pair_t item;
			item.src = p;
			item.want = paint_pair(p);
			awaited.push_back(item);
			noted++;
		endfunction

		function void check_pair(pair_out_t got);
			pending_pair_t head;
			logic [PIX_W-1:0] want_b[4];
			logic [PIX_W-1:0] got_b[4];
			string names[4];
			if (awaited.size() == 0) begin
				complain($sformatf("Output pair %h arrived with no pending item.", got));
				return;
			end
			head = awaited.pop_front();
			checked++;
			names = '{"out_u", "out_y0", "out_v", "out_y1"};
			want_b = '{head.want.u, head.want.y0, head.want.v, head.want.y1};
			got_b = '{got.u, got.y0, got.v, got.y1};
			for (int k = 0; k < 4; k++) begin
				if (got_b[k] !== want_b[k])
					complain($sformatf("Mismatch on %s at col %0d row %0d phase %0d: expected %02h, got %02h",
						names[k], head.src.col, head.src.row, head.src.phase, want_b[k], got_b[k]));
			end
		endfunction

		function void finish_check();
			if (awaited.size() != 0)
				complain($sformatf("%0d items never produced an output pair.", awaited.size()));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [COORD_W-1:0] col;
	logic [COORD_W-1:0] row;
	logic [PHASE_W-1:0] frame_phase;
	logic [PIX_W-1:0] in_u;
	logic [PIX_W-1:0] in_y0;
	logic [PIX_W-1:0] in_v;
	logic [PIX_W-1:0] in_y1;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [PIX_W-1:0] out_u;
	logic [PIX_W-1:0] out_y0;
	logic [PIX_W-1:0] out_v;
	logic [PIX_W-1:0] out_y1;

	pair_scoreboard sb;
	int tx_idle_pct;
	int rx_idle_pct;
	int hold_orders;
	int hold_served = 0;
	int hold_left = 0;
	int settings_run;

	av_sync_clapper_overlay_unit #(
		.MAX_DIM(DIM_LIMIT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.col(col),
		.row(row),
		.frame_phase(frame_phase),
		.in_u(in_u),
		.in_y0(in_y0),
		.in_v(in_v),
		.in_y1(in_y1),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_u(out_u),
		.out_y0(out_y0),
		.out_v(out_v),
		.out_y1(out_y1)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_pair('{col, row, frame_phase, in_u, in_y0, in_v, in_y1});
			if (out_valid && out_ready)
				sb.check_pair('{out_u, out_y0, out_v, out_y1});
		end
	end

	always @(negedge clk) begin
		if (hold_served != hold_orders) begin
			hold_served = hold_orders;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	function automatic int clip(int v);
		return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
	endfunction

	function automatic pair_in_t pair_at(int c, int r, int ph, logic [PIX_W-1:0] fill);
		pair_in_t p;
		p.col = COORD_W'(clip(c));
		p.row = COORD_W'(clip(r));
		p.phase = PHASE_W'(ph);
		p.u = fill;
		p.y0 = fill;
		p.v = fill;
		p.y1 = fill;
		return p;
	endfunction

	function automatic pair_in_t random_pair();
		int w, fps, bh, td, xm, y0, s, e, pick, c, r;
		pair_in_t p;
		sb.geometry(w, fps, bh, td, xm, y0, s, e);
		pick = $urandom_range(99);
		if (pick < 45) r = y0 - 1 + $urandom_range(bh + 1);
		else if (pick < 70) r = $urandom_range(bh + 1);
		else r = $urandom_range(COORD_MAX);
		pick = $urandom_range(99);
		if (pick < 50) c = s - 2 + $urandom_range(e - s + 4);
		else if (pick < 65)
			c = (pick % 2 == 1) ? FLASH_MARGIN - 2 + $urandom_range(3)
				: w - FLASH_MARGIN - 2 + $urandom_range(3);
		else c = $urandom_range(COORD_MAX);
		p.col = COORD_W'(clip(c));
		p.row = COORD_W'(clip(r));
		p.phase = ($urandom_range(4) == 0) ? PHASE_W'(sb.flash_phase()) : PHASE_W'($urandom);
		p.u = PIX_W'($urandom);
		p.y0 = PIX_W'($urandom);
		p.v = PIX_W'($urandom);
		p.y1 = PIX_W'($urandom);
		return p;
	endfunction

	task automatic send_pair(input pair_in_t p);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		col <= p.col;
		row <= p.row;
		frame_phase <= p.phase;
		in_u <= p.u;
		in_y0 <= p.y0;
		in_v <= p.v;
		in_y1 <= p.y1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		@(negedge clk);
	endtask

	task automatic configure(input int w, input int h, input bit pal_sel,
			input logic [COLOUR_W-1:0] grn, input logic [COLOUR_W-1:0] blk, input bit spare);
		write_reg(REG_FRAME_WIDTH, {11'($urandom), CFG_DIM_W'(w)});
		write_reg(REG_FRAME_HEIGHT, {11'($urandom), CFG_DIM_W'(h)});
		write_reg(REG_IS_PAL, {23'($urandom), pal_sel});
		write_reg(REG_BAR_COLOR, grn);
		write_reg(REG_OFF_COLOR, blk);
		if (spare) write_reg(REG_SPARE, CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
		settings_run++;
	endtask

	task automatic run_phase(input int n, input int tx_pct, input int rx_pct, input bit hold);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		if (hold) hold_orders++;
		repeat (n) send_pair(random_pair());
		in_valid <= 1'b0;
		while (sb.awaited.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		int w, fps, bh, td, xm, y0, s, e, fl;
		sb = new();
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		col = '0;
		row = '0;
		frame_phase = '0;
		in_u = '0;
		in_y0 = '0;
		in_v = '0;
		in_y1 = '0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_orders = 0;
		settings_run = 1;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		sb.geometry(w, fps, bh, td, xm, y0, s, e);
		fl = sb.flash_phase();
		send_pair(pair_at(FLASH_MARGIN, 0, fl, 8'h00));
		send_pair(pair_at(FLASH_MARGIN - 2, 0, fl, 8'hff));
		send_pair(pair_at(w - FLASH_MARGIN - 2, bh - 1, 0, 8'h5a));
		send_pair(pair_at(w - FLASH_MARGIN, bh - 1, fl, 8'ha5));
		send_pair(pair_at(100, bh, fl, 8'h33));
		send_pair(pair_at(FLASH_MARGIN + 1, 1, fl + 1, 8'hcc));
		send_pair(pair_at(s, y0, 0, 8'h00));
		send_pair(pair_at(s + td, y0, 0, 8'hff));
		send_pair(pair_at(s + 1, y0, 3, 8'h11));
		send_pair(pair_at(e - 2, y0, fps - 1, 8'h22));
		send_pair(pair_at(e - 1, y0, 0, 8'h44));
		send_pair(pair_at(e, y0, 31, 8'h88));
		send_pair(pair_at(xm, y0 + 1, 0, 8'h77));
		send_pair(pair_at(xm + td, y0 + 1, 1, 8'hee));
		send_pair(pair_at(w - 2, y0 + 1, 30, 8'h99));
		send_pair(pair_at(s - 2, y0 + bh - 1, 5, 8'h66));
		send_pair(pair_at(s, y0 + bh, 5, 8'h55));
		send_pair(pair_at(s, y0 - 1, 5, 8'hbb));
		send_pair(pair_at(COORD_MAX, COORD_MAX, 31, 8'hff));
		send_pair(pair_at(0, 0, 0, 8'h00));
		run_phase(70, 0, 0, 1'b0);

		configure(16, 16, 1'b0, 24'h000000, 24'hffffff, 1'b0);
		run_phase(80, 49, 0, 1'b0);
		configure(8191, 8191, 1'b1, 24'hffffff, 24'h000000, 1'b0);
		run_phase(90, 0, 49, 1'b0);
		configure(4096, 4096, 1'b0, COLOUR_W'($urandom), COLOUR_W'($urandom), 1'b0);
		run_phase(90, 11, 11, 1'b0);
		configure(100, 30, 1'b1, COLOUR_W'($urandom), COLOUR_W'($urandom), 1'b0);
		run_phase(90, 0, 0, 1'b1);
		configure(37, 3, 1'b1, COLOUR_W'($urandom), COLOUR_W'($urandom), 1'b1);
		run_phase(70, 49, 0, 1'b0);
		configure($urandom_range(2000, 16), $urandom_range(2000, 16), 1'($urandom),
			COLOUR_W'($urandom), COLOUR_W'($urandom), 1'b0);
		run_phase(90, 11, 11, 1'b0);
		configure(0, 0, 1'b0, COLOUR_W'($urandom), COLOUR_W'($urandom), 1'b0);
		run_phase(30, 0, 49, 1'b0);

		sb.finish_check();
		$display("Checked %0d of %0d pixel pairs across %0d register settings, both frame rates.",
			sb.checked, sb.noted, settings_run);
		$display("Found %0d mismatches or lost pairs.", sb.errors);
		if (sb.errors == 0) begin
			$display("[av_sync_clapper_overlay_unit] OK");
		end else begin
			$display("[av_sync_clapper_overlay_unit] ERROR");
		end
		$finish;
	end

	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("Timed out with %0d pairs outstanding.", sb.awaited.size());
		$display("[av_sync_clapper_overlay_unit] ERROR");
		$finish;
	end

endmodule

// ----- av_sync_clapper_overlay_unit.f -----
hw/rtl/avclap_pkg.sv
hw/rtl/avclap_geom.sv
hw/rtl/avclap_pipe.sv
hw/rtl/av_sync_clapper_overlay_unit.sv
hw/rtl/avclap_checker.sv
tb/sv/tb.sv
